### src/deq_pkg.sv
`timescale 1ns / 1ps
// deq_pkg: shared constants, codes and beat types for the double-ended queue
// used by deq_cell and double_ended_queue; depends on nothing

package deq_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 64;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [63:0] push_value;
    } t_req;

    typedef struct packed {
        logic [63:0] pop_value;
        t_status     status;
        logic [6:0]  occupancy;
        logic        is_empty;
    } t_rsp;

    // broadcast to every cell of the row
    typedef struct packed {
        logic    go;
        t_action action;
    } t_cell_ctl;

endpackage

### src/double_ended_queue.sv
`timescale 1ns / 1ps
// double_ended_queue: top level, a row of deq_cell slots plus response register
// depends on deq_pkg and deq_cell

// Bounded double-ended queue of words held in a row of DEPTH cells; the front
// word always sits in cell 0 and the occupied cells form one run from there.
// A request is taken on any clock edge where start is high and busy is low;
// busy never rises, so one request can be issued every cycle. Each request
// returns exactly one response beat on o_rsp, flagged by o_rsp_valid for one
// cycle, in the cycle right after the request edge; the receiver has no way
// to hold it and must take it then. The rate is one request per cycle,
// set by the cell row: every cell loads its next word from a neighbor, the
// push word or itself in that single cycle. A push on a full queue reports
// full and stores nothing, a pop on an empty queue reports empty and returns
// zero; in both cases the queue is left as it was. Every response carries
// the occupancy after the request and an empty flag.

module double_ended_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  deq_pkg::t_req   i_req,
    output logic            o_rsp_valid,
    output deq_pkg::t_rsp   o_rsp
);
    import deq_pkg::*;

    // cell row wiring
    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_tail;
    logic [WORD_WIDTH-1:0] w_data       [DEPTH];
    logic [DEPTH-1:0]      w_left_valid;
    logic [WORD_WIDTH-1:0] w_left_data  [DEPTH];
    logic [DEPTH-1:0]      w_right_valid;
    logic [WORD_WIDTH-1:0] w_right_data [DEPTH];

    logic [WORD_WIDTH-1:0] w_push_word;
    logic [WORD_WIDTH-1:0] w_back_data;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_is_push;
    logic                  w_ok;
    t_cell_ctl             w_ctl;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_rsp_valid;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;

    // never stalls
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // word masked to the stored width
    assign w_push_word = WORD_WIDTH'(i_req.push_value);

    // full and empty straight off the row ends
    assign w_full    = w_valid[DEPTH-1];
    assign w_empty   = ~w_valid[0];
    assign w_is_push = (i_req.action == ACT_PUSH_FRONT) || (i_req.action == ACT_PUSH_BACK);
    assign w_ok      = w_is_push ? ~w_full : ~w_empty;

    assign w_ctl.go     = w_accept & w_ok;
    assign w_ctl.action = i_req.action;

    // neighbor links; cell 0 sees the push word as its left neighbor
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_link
            if (gi == 0) begin : g_first
                assign w_left_valid[gi] = 1'b1;
                assign w_left_data[gi]  = w_push_word;
            end else begin : g_mid_l
                assign w_left_valid[gi] = w_valid[gi-1];
                assign w_left_data[gi]  = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right_valid[gi] = 1'b0;
                assign w_right_data[gi]  = '0;
            end else begin : g_mid_r
                assign w_right_valid[gi] = w_valid[gi+1];
                assign w_right_data[gi]  = w_data[gi+1];
            end

            deq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_push_word   (w_push_word),
                .i_left_valid  (w_left_valid[gi]),
                .i_left_data   (w_left_data[gi]),
                .i_right_valid (w_right_valid[gi]),
                .i_right_data  (w_right_data[gi]),
                .o_valid       (w_valid[gi]),
                .o_data        (w_data[gi]),
                .o_tail        (w_tail[gi])
            );
        end
    endgenerate

    // back word: one-hot select on the tail flag
    always_comb begin
        w_back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_data = w_back_data | (w_data[i] & {WORD_WIDTH{w_tail[i]}});
        end
    end

    // occupancy and response beat
    always_comb begin
        n_count          = r_count;
        n_rsp.pop_value  = '0;
        n_rsp.status     = ST_DONE;
        if (!w_ok) begin
            n_rsp.status = w_is_push ? ST_FULL : ST_EMPTY;
        end else begin
            case (i_req.action)
                ACT_PUSH_FRONT,
                ACT_PUSH_BACK: begin
                    n_count = r_count + CNT_W'(1);
                end
                ACT_POP_FRONT: begin
                    n_count         = r_count - CNT_W'(1);
                    n_rsp.pop_value = 64'(w_data[0]);
                end
                ACT_POP_BACK: begin
                    n_count         = r_count - CNT_W'(1);
                    n_rsp.pop_value = 64'(w_back_data);
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
        n_rsp.occupancy = 7'(n_count);
        n_rsp.is_empty  = (n_count == CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // at most one tail cell, so the occupied cells form no more than one run
    a_one_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tail))
        else $error("more than one tail cell");

    // count agrees with the row at the empty end
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(0)) == w_empty)
        else $error("count and row disagree on empty");

    // count agrees with the row at the full end
    a_full_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(DEPTH)) == w_full)
        else $error("count and row disagree on full");

    // one response beat per request, in the next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_rsp_valid)
        else $error("missing response beat");

    a_no_stray_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_rsp_valid)
        else $error("response beat without request");

    // a refused push leaves the queue full
    a_full_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ST_FULL) |-> w_full)
        else $error("full status while queue not full");

endmodule

### src/deq_cell.sv
`timescale 1ns / 1ps
// deq_cell: one slot of the queue row, holds a word and an occupied flag
// depends on deq_pkg

module deq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  deq_pkg::t_cell_ctl                i_ctl,
    input  logic [deq_pkg::WORD_WIDTH-1:0]    i_push_word,
    input  logic                              i_left_valid,
    input  logic [deq_pkg::WORD_WIDTH-1:0]    i_left_data,
    input  logic                              i_right_valid,
    input  logic [deq_pkg::WORD_WIDTH-1:0]    i_right_data,
    output logic                              o_valid,
    output logic [deq_pkg::WORD_WIDTH-1:0]    o_data,
    output logic                              o_tail
);
    import deq_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [WORD_WIDTH-1:0] r_data;
    logic [WORD_WIDTH-1:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.go) begin
            case (i_ctl.action)
                ACT_PUSH_FRONT: begin
                    // whole row moves one slot toward the back
                    n_valid = i_left_valid;
                    n_data  = i_left_data;
                end
                ACT_PUSH_BACK: begin
                    // first free slot takes the word
                    if (!r_valid && i_left_valid) begin
                        n_valid = 1'b1;
                        n_data  = i_push_word;
                    end
                end
                ACT_POP_FRONT: begin
                    n_valid = i_right_valid;
                    n_data  = i_right_data;
                end
                ACT_POP_BACK: begin
                    if (r_valid && !i_right_valid) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_tail  = r_valid & ~i_right_valid;

endmodule
